[rtl/nar_pkg.sv]
// shared types and constants for the no-adjacent-repeat reorder block
package nar_pkg;

    localparam int ValW   = 12;
    localparam int NumVal = 4096;
    localparam int CntW   = 13;
    localparam int MaxItems = 4096;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_PULL  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;
    localparam logic [1:0] KIND_RSVD  = 2'd3;

    localparam logic [1:0] STATUS_EMIT  = 2'd0;
    localparam logic [1:0] STATUS_DONE  = 2'd1;
    localparam logic [1:0] STATUS_STUCK = 2'd2;

    typedef struct packed {
        logic             load;      // increment count at request value
        logic             clr_start; // begin clearing sweep
        logic             scan_start;// begin max scan
        logic             commit;    // apply scan result
        logic [ValW-1:0]  value;
    } nar_cmd_t;

    typedef struct packed {
        logic             busy;      // sweep, scan or update running
        logic             res_valid; // scan result ready (one cycle)
        logic [ValW-1:0]  emitted;
        logic [1:0]       status;
    } nar_stat_t;

endpackage

[rtl/nar_datapath.sv]
// count memory, scanning search and previous-value tracking
module nar_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  nar_pkg::nar_cmd_t  cmd,
    output nar_pkg::nar_stat_t stat
);

    typedef enum logic [4:0] {
        D_IDLE  = 5'b00001,
        D_CLR   = 5'b00010,
        D_LDRD  = 5'b00100,
        D_SCAN  = 5'b01000,
        D_DEC   = 5'b10000
    } dstate_t;

    logic [nar_pkg::CntW-1:0] mem [nar_pkg::NumVal];
    logic [nar_pkg::CntW-1:0] rd_data_reg;

    dstate_t                  st_reg, st_next;
    logic [nar_pkg::ValW:0]   addr_reg, addr_next;     // one extra bit for end
    logic [nar_pkg::ValW-1:0] ld_val_reg, ld_val_next;
    logic [nar_pkg::ValW-1:0] prev_reg, prev_next;
    logic                     prev_vld_reg, prev_vld_next;
    logic [nar_pkg::CntW-1:0] total_reg, total_next;
    logic                     found_reg, found_next;
    logic                     any_reg, any_next;
    logic [nar_pkg::CntW-1:0] best_cnt_reg, best_cnt_next;
    logic [nar_pkg::ValW-1:0] best_val_reg, best_val_next;
    logic                     rvld_reg, rvld_next;     // read data in flight
    logic [nar_pkg::ValW-1:0] raddr_reg;               // address of rd_data_reg
    logic                     res_reg, res_next;

    logic                     we;
    logic [nar_pkg::ValW-1:0] waddr;
    logic [nar_pkg::CntW-1:0] wdata;
    logic [nar_pkg::ValW-1:0] raddr;
    logic                     re;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem[raddr];
        end
        raddr_reg <= raddr;
    end

    always_comb
    begin
        st_next       = st_reg;
        addr_next     = addr_reg;
        ld_val_next   = ld_val_reg;
        prev_next     = prev_reg;
        prev_vld_next = prev_vld_reg;
        total_next    = total_reg;
        found_next    = found_reg;
        any_next      = any_reg;
        best_cnt_next = best_cnt_reg;
        best_val_next = best_val_reg;
        rvld_next     = 1'b0;
        res_next      = 1'b0;
        we    = 1'b0;
        waddr = addr_reg[nar_pkg::ValW-1:0];
        wdata = '0;
        raddr = addr_reg[nar_pkg::ValW-1:0];
        re    = 1'b0;
        unique case (st_reg)
            D_IDLE:
            begin
                if (cmd.clr_start)
                begin
                    st_next       = D_CLR;
                    addr_next     = '0;
                    prev_next     = '0;
                    prev_vld_next = 1'b0;
                    total_next    = '0;
                end
                else if (cmd.load)
                begin
                    if (total_reg < nar_pkg::CntW'(nar_pkg::MaxItems))
                    begin
                        st_next     = D_LDRD;
                        ld_val_next = cmd.value;
                        raddr       = cmd.value;
                        re          = 1'b1;
                        total_next  = total_reg + 1'b1;
                    end
                end
                else if (cmd.scan_start)
                begin
                    st_next    = D_SCAN;
                    addr_next  = '0;
                    found_next = 1'b0;
                    any_next   = 1'b0;
                    best_cnt_next = '0;
                    best_val_next = '0;
                end
                else if (cmd.commit && found_reg)
                begin
                    st_next = D_DEC;
                    raddr   = best_val_reg;
                    re      = 1'b1;
                end
            end
            D_CLR:
            begin
                we        = 1'b1;
                wdata     = '0;
                addr_next = addr_reg + 1'b1;
                if (addr_reg[nar_pkg::ValW-1:0] == nar_pkg::ValW'(nar_pkg::NumVal - 1))
                begin
                    st_next = D_IDLE;
                end
            end
            D_LDRD:
            begin
                // read data now valid, write incremented count
                we      = 1'b1;
                waddr   = ld_val_reg;
                wdata   = rd_data_reg + 1'b1;
                st_next = D_IDLE;
            end
            D_SCAN:
            begin
                // issue read at addr_reg, consume previous read
                if (!addr_reg[nar_pkg::ValW])
                begin
                    re        = 1'b1;
                    rvld_next = 1'b1;
                    addr_next = addr_reg + 1'b1;
                end
                if (rvld_reg && rd_data_reg != '0)
                begin
                    any_next = 1'b1;
                    if (!(prev_vld_reg && raddr_reg == prev_reg) &&
                        (!found_reg || rd_data_reg >= best_cnt_reg))
                    begin
                        found_next    = 1'b1;
                        best_cnt_next = rd_data_reg;
                        best_val_next = raddr_reg;
                    end
                end
                if (addr_reg[nar_pkg::ValW] && !rvld_reg)
                begin
                    st_next  = D_IDLE;
                    res_next = 1'b1;
                end
            end
            D_DEC:
            begin
                we            = 1'b1;
                waddr         = best_val_reg;
                wdata         = rd_data_reg - 1'b1;
                prev_next     = best_val_reg;
                prev_vld_next = 1'b1;
                st_next       = D_IDLE;
            end
            default:
            begin
                st_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= D_CLR;  // clearing sweep after reset
            addr_reg     <= '0;
            prev_vld_reg <= 1'b0;
            prev_reg     <= '0;
            total_reg    <= '0;
            found_reg    <= 1'b0;
            any_reg      <= 1'b0;
            rvld_reg     <= 1'b0;
            res_reg      <= 1'b0;
        end
        else
        begin
            st_reg       <= st_next;
            addr_reg     <= addr_next;
            prev_vld_reg <= prev_vld_next;
            prev_reg     <= prev_next;
            total_reg    <= total_next;
            found_reg    <= found_next;
            any_reg      <= any_next;
            rvld_reg     <= rvld_next;
            res_reg      <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ld_val_reg   <= ld_val_next;
        best_cnt_reg <= best_cnt_next;
        best_val_reg <= best_val_next;
    end

    always_comb
    begin
        stat.busy      = (st_reg != D_IDLE);
        stat.res_valid = res_reg;
        stat.emitted   = found_reg ? best_val_reg : '0;
        stat.status    = found_reg ? nar_pkg::STATUS_EMIT :
                         (any_reg ? nar_pkg::STATUS_STUCK : nar_pkg::STATUS_DONE);
    end

    a_total_max: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= nar_pkg::CntW'(nar_pkg::MaxItems))
        else $error("load total above limit");
    a_found_any: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> any_reg)
        else $error("found without any count");
    a_res_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_reg |-> st_reg == D_IDLE)
        else $error("result while busy");
    a_best_not_prev: assert property (@(posedge clk) disable iff (!rst_n)
        res_reg && found_reg && prev_vld_reg |-> best_val_reg != prev_reg)
        else $error("repeat of previous value");

endmodule

[rtl/nar_ctrl.sv]
// request handshake and sequencing of the datapath
module nar_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         kind,
    input  logic [11:0]        value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [11:0]        emitted,
    output logic [1:0]         status,
    output nar_pkg::nar_cmd_t  cmd,
    input  nar_pkg::nar_stat_t stat
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_WAIT   = 4'b0010,
        S_SCAN   = 4'b0100,
        S_COMMIT = 4'b1000
    } cstate_t;

    cstate_t     st_reg, st_next;
    logic        ov_reg, ov_next;
    logic        acc;
    logic        free;

    // held result until slot frees
    logic [11:0] hold_em_reg;
    logic [1:0]  hold_st_reg;
    logic [11:0] out_em_reg;
    logic [1:0]  out_st_reg;

    assign free     = (st_reg == S_IDLE) && !stat.busy;
    assign in_stall = !free;
    assign acc      = in_valid && !in_stall;

    always_comb
    begin
        st_next   = st_reg;
        ov_next   = ov_reg && out_stall;
        cmd       = '0;
        cmd.value = value;
        unique case (st_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    unique case (kind)
                        nar_pkg::KIND_LOAD:  cmd.load = 1'b1;
                        nar_pkg::KIND_CLEAR: cmd.clr_start = 1'b1;
                        nar_pkg::KIND_PULL:
                        begin
                            cmd.scan_start = 1'b1;
                            st_next = S_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (stat.res_valid)
                begin
                    st_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                // result slot must be free before the result lands
                if (!ov_reg || !out_stall)
                begin
                    ov_next    = 1'b1;
                    cmd.commit = 1'b1;
                    st_next    = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                st_next = S_IDLE;
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == S_SCAN && stat.res_valid)
        begin
            hold_em_reg <= stat.emitted;
            hold_st_reg <= stat.status;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == S_WAIT && (!ov_reg || !out_stall))
        begin
            out_em_reg <= hold_em_reg;
            out_st_reg <= hold_st_reg;
        end
    end

    assign out_valid = ov_reg;
    assign emitted   = out_em_reg;
    assign status    = out_st_reg;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(emitted) && $stable(status))
        else $error("stalled result changed");
    a_no_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
        stat.busy |-> in_stall)
        else $error("request taken while busy");
    a_commit_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> !cmd.commit)
        else $error("double commit");

endmodule

[rtl/no_adjacent_repeat_reorder.sv]
// top level of the no-adjacent-repeat reorder block
//  channel | dir | handshake             | fields
//  request | in  | in_valid / in_stall   | kind, value
//  result  | out | out_valid / out_stall | emitted, status
// load: a read, then a write of the incremented count; clear: one count entry per cycle
// pull: a full sweep of the count memory through its read port
// after reset a clearing pass runs with in_stall high
// a waiting result does not block the next request; a pull waits for the result slot
module no_adjacent_repeat_reorder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [11:0] value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [11:0] emitted,
    output logic [1:0]  status
);

    nar_pkg::nar_cmd_t  cmd;
    nar_pkg::nar_stat_t stat;

    nar_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .emitted   (emitted),
        .status    (status),
        .cmd       (cmd),
        .stat      (stat)
    );

    nar_datapath u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat)
    );

endmodule
